FILE: hw/rtl/wms_pkg.sv
// wms_pkg: shared types and constants for the winnowing minhash signature block
// depends on nothing; used by wms_front, wms_queue, wms_back and the top level
package wms_pkg;

    localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
    localparam int          MIX_SHIFT_A = 30;
    localparam int          MIX_SHIFT_B = 27;
    localparam int          MIX_SHIFT_C = 31;

    localparam logic KIND_FINGERPRINT = 1'b0;
    localparam logic KIND_SIGNATURE   = 1'b1;

    // one classified word from front to back
    typedef struct packed {
        logic        has_fp;
        logic [63:0] fp;
        logic        eos;
    } task_t;

endpackage

FILE: hw/rtl/wms_front.sv
// wms_front: window ring, fill tracking, windowed minimum and duplicate drop
// depends on wms_pkg; produces task_t words for the task queue
module wms_front #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [6:0]          window_size,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [63:0]         hash_value,
    input  logic                end_of_stream,
    output logic                task_valid,
    input  logic                task_stall,
    output wms_pkg::task_t      task_word
);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [63:0] ring_mem [MAX_WINDOW];
    logic [63:0] rd_data_reg;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] wslot_reg, wslot_next;
    logic [63:0]   prev_fp_reg, prev_fp_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [CW-1:0] left_reg, left_next;
    logic [AW-1:0] rslot_reg, rslot_next;
    logic [63:0]   best_reg, best_next;
    logic          eos_reg, eos_next;
    logic          want_reg, want_next;
    logic          pend_reg, pend_next;
    wms_pkg::task_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0] win_eff;
    logic [CW-1:0] fill_inc;
    logic          accept;
    logic          rd_en;
    logic [AW-1:0] prev_slot;

    // clamp window into 1..MAX_WINDOW
    always_comb
    begin
        if (window_size == 7'd0)
            win_eff = CW'(1);
        else if (32'(window_size) > MAX_WINDOW)
            win_eff = CW'(MAX_WINDOW);
        else
            win_eff = CW'(window_size);
    end

    assign in_stall   = (state_reg != S_IDLE) || out_valid_reg;
    assign accept     = in_valid && !in_stall;
    assign task_valid = out_valid_reg;
    assign task_word  = out_reg;
    assign fill_inc   = (32'(fill_reg) < MAX_WINDOW) ? fill_reg + CW'(1) : fill_reg;

    always_comb
    begin
        if (rslot_reg == AW'(0))
            prev_slot = AW'(MAX_WINDOW - 1);
        else
            prev_slot = rslot_reg - AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ring_mem[wslot_reg] <= hash_value;
        if (rd_en)
            rd_data_reg <= ring_mem[prev_slot];
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        wslot_next      = wslot_reg;
        prev_fp_next    = prev_fp_reg;
        prev_valid_next = prev_valid_reg;
        left_next       = left_reg;
        rslot_next      = rslot_reg;
        best_next       = best_reg;
        eos_next        = eos_reg;
        want_next       = want_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        rd_en           = 1'b0;

        if (out_valid_reg && !task_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wslot_next = (32'(wslot_reg) + 1 >= MAX_WINDOW) ? AW'(0) : wslot_reg + AW'(1);
                    fill_next  = fill_inc;
                    rslot_next = (32'(wslot_reg) + 1 >= MAX_WINDOW) ? AW'(0) : wslot_reg + AW'(1);
                    eos_next   = end_of_stream;
                    best_next  = '1;
                    pend_next  = 1'b0;
                    if (fill_inc >= win_eff)
                    begin
                        want_next = 1'b1;
                        left_next = win_eff;
                    end
                    else if (end_of_stream && !prev_valid_reg)
                    begin
                        want_next = 1'b1;
                        left_next = fill_inc;
                    end
                    else
                    begin
                        want_next = 1'b0;
                        left_next = '0;
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one ring read per cycle, newest first
                if (pend_reg && rd_data_reg < best_reg)
                    best_next = rd_data_reg;
                if (want_reg && left_reg != '0)
                begin
                    rd_en      = 1'b1;
                    rslot_next = prev_slot;
                    left_next  = left_reg - CW'(1);
                    pend_next  = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = S_READ;
                end
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_next.has_fp = want_reg &&
                                      !(prev_valid_reg && prev_fp_reg == best_reg);
                    out_next.fp     = best_reg;
                    out_next.eos    = eos_reg;
                    if (out_next.has_fp || eos_reg)
                        out_valid_next = 1'b1;
                    if (eos_reg)
                    begin
                        fill_next       = '0;
                        wslot_next      = '0;
                        prev_fp_next    = '0;
                        prev_valid_next = 1'b0;
                    end
                    else if (out_next.has_fp)
                    begin
                        prev_fp_next    = best_reg;
                        prev_valid_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            wslot_reg      <= '0;
            prev_fp_reg    <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            want_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            wslot_reg      <= wslot_next;
            prev_fp_reg    <= prev_fp_next;
            prev_valid_reg <= prev_valid_next;
            out_valid_reg  <= out_valid_next;
            pend_reg       <= pend_next;
            want_reg       <= want_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        rslot_reg <= rslot_next;
        best_reg  <= best_next;
        eos_reg   <= eos_next;
        out_reg   <= out_next;
    end

endmodule

FILE: hw/rtl/wms_queue.sv
// wms_queue: small task fifo between front and back
// depends on wms_pkg for task_t
module wms_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_stall,
    input  wms_pkg::task_t wr_word,
    output logic           rd_valid,
    input  logic           rd_stall,
    output wms_pkg::task_t rd_word
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wms_pkg::task_t slot_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;
    logic           push, pop;

    assign wr_stall = (32'(cnt_reg) == DEPTH);
    assign rd_valid = (cnt_reg != '0);
    assign rd_word  = slot_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (32'(wp_reg) == DEPTH - 1) ? AW'(0) : wp_reg + AW'(1);
            if (pop)
                rp_reg <= (32'(rp_reg) == DEPTH - 1) ? AW'(0) : rp_reg + AW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

FILE: hw/rtl/wms_back.sv
// wms_back: splitmix64 pipeline, signature minima, result output register
// depends on wms_pkg
module wms_back #(
    parameter int SIGNATURE_WORDS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           task_valid,
    output logic           task_stall,
    input  wms_pkg::task_t task_word,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           kind,
    output logic [63:0]    value,
    output logic [5:0]     word_index,
    output logic           last
);
    localparam int IW = (SIGNATURE_WORDS > 1) ? $clog2(SIGNATURE_WORDS) : 1;
    localparam int LAT = 8;
    localparam int DW = $clog2(LAT + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FPO  = 3'd1;
    localparam logic [2:0] S_MIX  = 3'd2;
    localparam logic [2:0] S_SIG  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [DW-1:0] drain_reg, drain_next;
    wms_pkg::task_t cur_reg, cur_next;
    logic [SIGNATURE_WORDS-1:0] sig_set_reg, sig_set_next;
    logic [63:0]   sig_mem [SIGNATURE_WORDS];

    logic          o_valid_reg, o_valid_next;
    logic          o_kind_reg, o_kind_next;
    logic [63:0]   o_value_reg, o_value_next;
    logic [5:0]    o_idx_reg, o_idx_next;
    logic          o_last_reg, o_last_next;

    // mix pipeline: add | xor-shift | mul (2 cuts) | xor-shift | mul (2 cuts) | xor-shift
    logic [LAT-1:0] p_v_reg;
    logic [IW-1:0]  p_i_reg [LAT];
    logic [63:0]    p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg, p8_reg;
    logic [31:0]    p3_hh_reg, p6_hh_reg;
    logic           p_in;
    logic [63:0]    sig_cur;
    logic [63:0]    sig_word;
    logic           out_free;

    assign task_stall = (state_reg != S_IDLE);
    assign out_free   = !o_valid_reg || !out_stall;
    assign out_valid  = o_valid_reg;
    assign kind       = o_kind_reg;
    assign value      = o_value_reg;
    assign word_index = o_idx_reg;
    assign last       = o_last_reg;

    assign sig_cur  = sig_set_reg[p_i_reg[LAT-1]] ? sig_mem[p_i_reg[LAT-1]] : '1;
    assign sig_word = sig_set_reg[idx_reg] ? sig_mem[idx_reg] : '1;

    always_ff @(posedge clk)
    begin
        p1_reg    <= (cur_reg.fp ^ 64'(idx_reg)) + wms_pkg::MIX_GOLDEN;
        p2_reg    <= p1_reg ^ (p1_reg >> wms_pkg::MIX_SHIFT_A);
        p3_reg    <= 64'(p2_reg[31:0]) * 64'(wms_pkg::MIX_MUL_A[31:0])
                     + {p2_reg[31:0] * wms_pkg::MIX_MUL_A[63:32], 32'd0};
        p3_hh_reg <= p2_reg[63:32] * wms_pkg::MIX_MUL_A[31:0];
        p4_reg    <= p3_reg + {p3_hh_reg, 32'd0};
        p5_reg    <= p4_reg ^ (p4_reg >> wms_pkg::MIX_SHIFT_B);
        p6_reg    <= 64'(p5_reg[31:0]) * 64'(wms_pkg::MIX_MUL_B[31:0])
                     + {p5_reg[31:0] * wms_pkg::MIX_MUL_B[63:32], 32'd0};
        p6_hh_reg <= p5_reg[63:32] * wms_pkg::MIX_MUL_B[31:0];
        p7_reg    <= p6_reg + {p6_hh_reg, 32'd0};
        p8_reg    <= p7_reg ^ (p7_reg >> wms_pkg::MIX_SHIFT_C);
        p_i_reg[0] <= idx_reg;
        for (int k = 1; k < LAT; k++)
            p_i_reg[k] <= p_i_reg[k-1];
        if (p_v_reg[LAT-1] && p8_reg < sig_cur)
            sig_mem[p_i_reg[LAT-1]] <= p8_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        drain_next   = drain_reg;
        cur_next     = cur_reg;
        sig_set_next = sig_set_reg;
        o_valid_next = o_valid_reg;
        o_kind_next  = o_kind_reg;
        o_value_next = o_value_reg;
        o_idx_next   = o_idx_reg;
        o_last_next  = o_last_reg;
        p_in         = 1'b0;

        if (o_valid_reg && !out_stall)
            o_valid_next = 1'b0;
        if (p_v_reg[LAT-1] && p8_reg < sig_cur)
            sig_set_next[p_i_reg[LAT-1]] = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (task_valid)
                begin
                    cur_next = task_word;
                    idx_next = '0;
                    state_next = task_word.has_fp ? S_FPO : S_SIG;
                end
            end
            S_FPO:
            begin
                if (out_free)
                begin
                    o_valid_next = 1'b1;
                    o_kind_next  = wms_pkg::KIND_FINGERPRINT;
                    o_value_next = cur_reg.fp;
                    o_idx_next   = '0;
                    o_last_next  = 1'b0;
                    state_next   = S_MIX;
                end
            end
            S_MIX:
            begin
                // one word enters the mix pipeline per cycle
                p_in = (32'(drain_reg) == 0);
                if (32'(drain_reg) == 0)
                begin
                    if (32'(idx_reg) == SIGNATURE_WORDS - 1)
                    begin
                        idx_next   = '0;
                        drain_next = DW'(1);
                    end
                    else
                        idx_next = idx_reg + IW'(1);
                end
                else if (32'(drain_reg) == LAT + 1)
                begin
                    drain_next = '0;
                    state_next = cur_reg.eos ? S_SIG : S_IDLE;
                end
                else
                    drain_next = drain_reg + DW'(1);
            end
            S_SIG:
            begin
                if (out_free)
                begin
                    o_valid_next = 1'b1;
                    o_kind_next  = wms_pkg::KIND_SIGNATURE;
                    o_value_next = sig_word;
                    o_idx_next   = 6'(idx_reg);
                    o_last_next  = (32'(idx_reg) == SIGNATURE_WORDS - 1);
                    if (32'(idx_reg) == SIGNATURE_WORDS - 1)
                    begin
                        idx_next     = '0;
                        sig_set_next = '0;
                        state_next   = S_DONE;
                    end
                    else
                        idx_next = idx_reg + IW'(1);
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            drain_reg   <= '0;
            sig_set_reg <= '0;
            o_valid_reg <= 1'b0;
            p_v_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            drain_reg   <= drain_next;
            sig_set_reg <= sig_set_next;
            o_valid_reg <= o_valid_next;
            p_v_reg     <= {p_v_reg[LAT-2:0], p_in};
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        o_kind_reg  <= o_kind_next;
        o_value_reg <= o_value_next;
        o_idx_reg   <= o_idx_next;
        o_last_reg  <= o_last_next;
    end

endmodule

FILE: hw/rtl/winnowing_minhash_signature.sv
// winnowing_minhash_signature: top level, front/queue/back wiring and config register
// depends on wms_pkg, wms_front, wms_queue, wms_back
//
// Winnowing fingerprinter with a MinHash signature. Each accepted hash word is stored
// in a MAX_WINDOW-deep ring; once window_size hashes of the stream are in, the front
// walks the newest window_size entries one per cycle and forwards a fingerprint unless
// it repeats the previous one (a stream that ends short with no fingerprint yet is
// scanned over what it holds). The front stalls the input while it handles a word and
// until its task is taken. The back emits the fingerprint, then runs an 8-stage
// splitmix64 pipeline one signature word per cycle, and on end_of_stream emits
// SIGNATURE_WORDS signature words one per cycle while the output is not stalled, last
// marking the final one, then clears the stream. A two-word queue lets the front scan
// the next hash while the back is busy. Write window_size only while idle; it
// persists across streams.
module winnowing_minhash_signature #(
    parameter int MAX_WINDOW      = 64,
    parameter int SIGNATURE_WORDS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] hash_value,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [63:0] value,
    output logic [5:0]  word_index,
    output logic        last
);
    logic [6:0]     window_size_reg;
    logic           f_valid, f_stall, b_valid, b_stall;
    wms_pkg::task_t f_word, b_word;

    // window length register, reset to 4
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= 7'd4;
        else if (cfg_we)
            window_size_reg <= cfg_wdata;
    end

    wms_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
        .clk(clk), .rst_n(rst_n), .window_size(window_size_reg),
        .in_valid(in_valid), .in_stall(in_stall),
        .hash_value(hash_value), .end_of_stream(end_of_stream),
        .task_valid(f_valid), .task_stall(f_stall), .task_word(f_word)
    );

    wms_queue #(.DEPTH(2)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_word(f_word),
        .rd_valid(b_valid), .rd_stall(b_stall), .rd_word(b_word)
    );

    wms_back #(.SIGNATURE_WORDS(SIGNATURE_WORDS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .task_valid(b_valid), .task_stall(b_stall), .task_word(b_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .value(value), .word_index(word_index), .last(last)
    );

endmodule
